// ----- sv/ffha_pkg.sv -----
// shared types and constants of the first-fit heap allocator
package ffha_pkg;

    localparam int HEAP_BYTES_DEF = 4096;
    localparam int HDR_BYTES      = 4;
    localparam int SPLIT_MIN      = 2 * HDR_BYTES;
    localparam int WORD_W         = 32;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_ZALLOC = 2'd1,
        OP_FREE   = 2'd2,
        OP_RESIZE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_INVALID  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DECODE, S_MUL, S_MULCHK,
        S_A_RD, S_A_CHK, S_F_RD, S_F_CHK, S_C_RD, S_C_CHK,
        S_FR_W1, S_FR_W2, S_FR_RN, S_FR_CN,
        S_RS_DEC, S_RS_RN, S_RS_CN,
        S_WR1, S_WR2, S_POST, S_DONE
    } state_t;

endpackage

// ----- sv/ffha_ram.sv -----
// generic single-write, single-read ram with registered read data
module ffha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/first_fit_heap_allocator.sv -----
// first-fit heap allocator top level: sequencer, datapath and header store
//
// usage: present operation, request_bytes, item_count and block_address with
// start high; the request is taken at a rising edge where busy is low. busy
// stays high until the result is shown. the result fields are valid for
// exactly one cycle with done high; the receiver cannot stall, so it must
// take the result in that cycle.
// walk: a request walks the address-ordered header list through the single
// read port of the header ram, addressing and then checking each header
// visited. a moving resize costs a free walk plus an allocate walk plus a
// free walk. zeroed allocate first forms the 16x16 product of item_count
// and request_bytes.
// throughput: one request at a time; the next may start the cycle after done.
// reset: busy is high for one cycle while header 0 is written as one free
// block covering the whole heap; no other header is cleared.
module first_fit_heap_allocator
#(
    parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [15:0] request_bytes,
    input  logic [15:0] item_count,
    input  logic [15:0] block_address,
    output logic        done,
    output logic [15:0] result_address,
    output logic [15:0] copy_source,
    output logic [15:0] copy_length,
    output logic [15:0] clear_length,
    output logic [1:0]  status
);

    import ffha_pkg::*;

    localparam int STORE_DEPTH = HEAP_BYTES / 2;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    state_t state_reg, state_next;

    // latched request
    logic [1:0]  op_reg, op_next;
    logic [15:0] req_reg, req_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] baddr_reg, baddr_next;

    // walk and block registers
    logic [16:0] need_reg, need_next;      // rounded size, may reach 65536
    logic [31:0] prod_reg, prod_next;
    logic [15:0] ptr_reg, ptr_next;        // walking header offset
    logic [15:0] cur_reg, cur_next;        // header of the target block
    logic [15:0] cnext_reg, cnext_next;    // link of the target block
    logic [15:0] csz_reg, csz_next;        // size of the target, used bit clear
    logic [15:0] prev_reg, prev_next;
    logic [15:0] prevsz_reg, prevsz_next;
    logic        resize_reg, resize_next;  // found block goes to resize, not free
    logic        move_reg, move_next;      // allocate is part of a moving resize
    logic        zero_reg, zero_next;      // zeroed allocate

    // pending pair of header writes for a split
    logic [15:0] w1a_reg, w1a_next;
    logic [31:0] w1d_reg, w1d_next;
    logic [15:0] w2a_reg, w2a_next;
    logic [31:0] w2d_reg, w2d_next;

    // result registers
    logic [15:0] res_reg, res_next;
    logic [15:0] csrc_reg, csrc_next;
    logic [15:0] clen_reg, clen_next;
    logic [15:0] zlen_reg, zlen_next;
    status_t     st_reg, st_next;

    // header ram ports
    logic        mem_we;
    logic [15:0] mem_woff;
    logic [31:0] mem_wdata;
    logic [15:0] mem_roff;
    logic [31:0] mem_rdata;

    ffha_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_woff[IDX_W:1]),
        .wdata (mem_wdata),
        .raddr (mem_roff[IDX_W:1]),
        .rdata (mem_rdata)
    );

    // fields of the header just read
    logic [15:0] d_next, d_size;
    assign d_next = mem_rdata[31:16];
    assign d_size = mem_rdata[15:0];

    // allocate: free block that fits and the split decision
    logic        a_fit, a_split;
    logic [15:0] a_rem, a_rest;
    assign a_fit   = !d_size[0] && ({1'b0, d_size} >= need_reg);
    assign a_rem   = d_size - need_reg[15:0];
    assign a_split = a_rem >= 16'(SPLIT_MIN);
    assign a_rest  = ptr_reg + 16'(HDR_BYTES) + need_reg[15:0];

    // resize in place
    logic        r_fits, r_split;
    logic [15:0] r_rest, r_rem;
    assign r_fits  = {1'b0, csz_reg} >= need_reg;
    assign r_rem   = csz_reg - need_reg[15:0];
    assign r_split = r_rem >= 16'(SPLIT_MIN);
    assign r_rest  = cur_reg + 16'(HDR_BYTES) + need_reg[15:0];

    // resize grow into the next free block
    logic [16:0] g_total, g_left;
    logic        g_ok, g_split;
    assign g_total = {1'b0, csz_reg} + 17'(HDR_BYTES) + {1'b0, d_size};
    assign g_left  = g_total - need_reg;
    assign g_ok    = !d_size[0] && (g_total >= need_reg);
    assign g_split = g_left > 17'(SPLIT_MIN);

    // free merge tests
    logic prev_merge;
    assign prev_merge = (prev_reg < cur_reg) && !prevsz_reg[0];

    // rounded request size
    logic [16:0] req_need;
    assign req_need = ({1'b0, req_reg} + 17'd1) & ~17'd1;

    logic        bad_addr;
    assign bad_addr = baddr_reg < 16'(HDR_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        req_reg    <= req_next;
        cnt_reg    <= cnt_next;
        baddr_reg  <= baddr_next;
        need_reg   <= need_next;
        prod_reg   <= prod_next;
        ptr_reg    <= ptr_next;
        cur_reg    <= cur_next;
        cnext_reg  <= cnext_next;
        csz_reg    <= csz_next;
        prev_reg   <= prev_next;
        prevsz_reg <= prevsz_next;
        resize_reg <= resize_next;
        move_reg   <= move_next;
        zero_reg   <= zero_next;
        w1a_reg    <= w1a_next;
        w1d_reg    <= w1d_next;
        w2a_reg    <= w2a_next;
        w2d_reg    <= w2d_next;
        res_reg    <= res_next;
        csrc_reg   <= csrc_next;
        clen_reg   <= clen_next;
        zlen_reg   <= zlen_next;
        st_reg     <= st_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (op_t'(op_reg))
                    OP_ALLOC:  state_next = S_A_RD;
                    OP_ZALLOC: state_next = S_MUL;
                    OP_FREE:
                    begin
                        state_next = (baddr_reg == 16'd0 || bad_addr) ? S_DONE : S_F_RD;
                    end
                    OP_RESIZE:
                    begin
                        if (req_reg != 16'd0 && baddr_reg == 16'd0)
                        begin
                            state_next = S_A_RD;
                        end
                        else
                        begin
                            state_next = (baddr_reg == 16'd0 || bad_addr) ? S_DONE : S_F_RD;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_MUL:
            begin
                state_next = S_MULCHK;
            end
            S_MULCHK:
            begin
                state_next = (prod_reg[31:16] != 16'd0) ? S_DONE : S_A_RD;
            end
            S_A_RD:
            begin
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (a_fit)
                begin
                    state_next = a_split ? S_WR1 : S_POST;
                end
                else
                begin
                    state_next = (d_next == 16'd0) ? S_DONE : S_A_RD;
                end
            end
            S_F_RD:
            begin
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (d_next == cur_reg)
                begin
                    state_next = S_C_RD;
                end
                else
                begin
                    state_next = (d_next == 16'd0) ? S_DONE : S_F_RD;
                end
            end
            S_C_RD:
            begin
                state_next = S_C_CHK;
            end
            S_C_CHK:
            begin
                if (!d_size[0])
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = resize_reg ? S_RS_DEC : S_FR_W1;
                end
            end
            S_FR_W1:
            begin
                state_next = prev_merge ? S_FR_W2 : S_FR_RN;
            end
            S_FR_W2:
            begin
                state_next = S_FR_RN;
            end
            S_FR_RN:
            begin
                state_next = (cur_reg < cnext_reg) ? S_FR_CN : S_DONE;
            end
            S_FR_CN:
            begin
                state_next = S_DONE;
            end
            S_RS_DEC:
            begin
                if (r_fits)
                begin
                    state_next = r_split ? S_WR1 : S_DONE;
                end
                else
                begin
                    state_next = (cnext_reg > cur_reg) ? S_RS_RN : S_A_RD;
                end
            end
            S_RS_RN:
            begin
                state_next = S_RS_CN;
            end
            S_RS_CN:
            begin
                if (g_ok)
                begin
                    state_next = g_split ? S_WR1 : S_DONE;
                end
                else
                begin
                    state_next = S_A_RD;
                end
            end
            S_WR1:
            begin
                state_next = S_WR2;
            end
            S_WR2:
            begin
                state_next = S_POST;
            end
            S_POST:
            begin
                state_next = move_reg ? S_F_RD : S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        op_next     = op_reg;
        req_next    = req_reg;
        cnt_next    = cnt_reg;
        baddr_next  = baddr_reg;
        need_next   = need_reg;
        prod_next   = prod_reg;
        ptr_next    = ptr_reg;
        cur_next    = cur_reg;
        cnext_next  = cnext_reg;
        csz_next    = csz_reg;
        prev_next   = prev_reg;
        prevsz_next = prevsz_reg;
        resize_next = resize_reg;
        move_next   = move_reg;
        zero_next   = zero_reg;
        w1a_next    = w1a_reg;
        w1d_next    = w1d_reg;
        w2a_next    = w2a_reg;
        w2d_next    = w2d_reg;
        res_next    = res_reg;
        csrc_next   = csrc_reg;
        clen_next   = clen_reg;
        zlen_next   = zlen_reg;
        st_next     = st_reg;
        mem_we      = 1'b0;
        mem_woff    = 16'd0;
        mem_wdata   = '0;
        mem_roff    = ptr_reg;

        case (state_reg)
            S_INIT:
            begin
                // header 0: one free block spanning the heap, linked to itself
                mem_we    = 1'b1;
                mem_wdata = {16'd0, 16'(HEAP_BYTES - HDR_BYTES)};
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = operation;
                    req_next    = request_bytes;
                    cnt_next    = item_count;
                    baddr_next  = block_address;
                    res_next    = 16'd0;
                    csrc_next   = 16'd0;
                    clen_next   = 16'd0;
                    zlen_next   = 16'd0;
                    st_next     = ST_OK;
                    move_next   = 1'b0;
                    zero_next   = 1'b0;
                    resize_next = 1'b0;
                end
            end
            S_DECODE:
            begin
                need_next = req_need;
                ptr_next  = 16'd0;
                cur_next  = baddr_reg - 16'(HDR_BYTES);
                if (op_t'(op_reg) == OP_RESIZE && req_reg != 16'd0 && baddr_reg != 16'd0)
                begin
                    resize_next = 1'b1;
                end
                if ((op_t'(op_reg) == OP_FREE || op_t'(op_reg) == OP_RESIZE) &&
                    baddr_reg != 16'd0 && bad_addr)
                begin
                    st_next = ST_INVALID;
                end
            end
            S_MUL:
            begin
                prod_next = {16'd0, cnt_reg} * {16'd0, req_reg};
            end
            S_MULCHK:
            begin
                zero_next = 1'b1;
                need_next = ({1'b0, prod_reg[15:0]} + 17'd1) & ~17'd1;
                if (prod_reg[31:16] != 16'd0)
                begin
                    st_next = ST_OVERFLOW;
                end
            end
            S_A_CHK:
            begin
                if (a_fit)
                begin
                    res_next = ptr_reg + 16'(HDR_BYTES);
                    if (zero_reg)
                    begin
                        zlen_next = prod_reg[15:0];
                    end
                    if (a_split)
                    begin
                        w1a_next = a_rest;
                        w1d_next = {d_next, a_rem - 16'(HDR_BYTES)};
                        w2a_next = ptr_reg;
                        w2d_next = {a_rest, need_reg[15:1], 1'b1};
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_woff  = ptr_reg;
                        mem_wdata = {d_next, d_size | 16'd1};
                    end
                end
                else
                begin
                    ptr_next = d_next;
                    if (d_next == 16'd0)
                    begin
                        st_next = ST_NO_SPACE;
                    end
                end
            end
            S_F_CHK:
            begin
                if (d_next == cur_reg)
                begin
                    prev_next   = ptr_reg;
                    prevsz_next = d_size;
                end
                else
                begin
                    ptr_next = d_next;
                    if (d_next == 16'd0)
                    begin
                        st_next = ST_INVALID;
                    end
                end
            end
            S_C_RD:
            begin
                mem_roff = cur_reg;
            end
            S_C_CHK:
            begin
                cnext_next = d_next;
                csz_next   = {d_size[15:1], 1'b0};
                if (!d_size[0])
                begin
                    st_next = ST_INVALID;
                end
            end
            S_FR_W1:
            begin
                mem_we    = 1'b1;
                mem_woff  = cur_reg;
                mem_wdata = {cnext_reg, csz_reg};
            end
            S_FR_W2:
            begin
                // merge into the free block before
                mem_we    = 1'b1;
                mem_woff  = prev_reg;
                mem_wdata = {cnext_reg, prevsz_reg + 16'(HDR_BYTES) + csz_reg};
                cur_next  = prev_reg;
                csz_next  = prevsz_reg + 16'(HDR_BYTES) + csz_reg;
            end
            S_FR_RN:
            begin
                mem_roff = cnext_reg;
            end
            S_FR_CN:
            begin
                // merge the free block after
                if (!d_size[0])
                begin
                    mem_we    = 1'b1;
                    mem_woff  = cur_reg;
                    mem_wdata = {d_next, csz_reg + 16'(HDR_BYTES) + d_size};
                end
            end
            S_RS_DEC:
            begin
                ptr_next = 16'd0;
                if (r_fits)
                begin
                    res_next = baddr_reg;
                    w1a_next = r_rest;
                    w1d_next = {cnext_reg, r_rem - 16'(HDR_BYTES)};
                    w2a_next = cur_reg;
                    w2d_next = {r_rest, need_reg[15:1], 1'b1};
                end
                else if (cnext_reg <= cur_reg)
                begin
                    move_next = 1'b1;
                end
            end
            S_RS_RN:
            begin
                mem_roff = cnext_reg;
            end
            S_RS_CN:
            begin
                if (g_ok)
                begin
                    res_next = baddr_reg;
                    if (g_split)
                    begin
                        w1a_next = r_rest;
                        w1d_next = {d_next, g_left[15:0] - 16'(HDR_BYTES)};
                        w2a_next = cur_reg;
                        w2d_next = {r_rest, need_reg[15:1], 1'b1};
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_woff  = cur_reg;
                        mem_wdata = {d_next, g_total[15:0] | 16'd1};
                    end
                end
                else
                begin
                    move_next = 1'b1;
                end
            end
            S_WR1:
            begin
                mem_we    = 1'b1;
                mem_woff  = w1a_reg;
                mem_wdata = w1d_reg;
            end
            S_WR2:
            begin
                mem_we    = 1'b1;
                mem_woff  = w2a_reg;
                mem_wdata = w2d_reg;
            end
            S_POST:
            begin
                // moved resize: report the copy and free the old block
                if (move_reg)
                begin
                    csrc_next   = baddr_reg;
                    clen_next   = csz_reg;
                    cur_next    = baddr_reg - 16'(HDR_BYTES);
                    ptr_next    = 16'd0;
                    resize_next = 1'b0;
                    move_next   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy           = state_reg != S_IDLE;
    assign done           = state_reg == S_DONE;
    assign result_address = res_reg;
    assign copy_source    = csrc_reg;
    assign copy_length    = clen_reg;
    assign clear_length   = zlen_reg;
    assign status         = st_reg;

    // a result is shown for one cycle only
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // an accepted request makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("request accepted without going busy");

    // a failed request reports no address
    a_fail_noaddr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (result_address == 16'd0 && clear_length == 16'd0))
        else $error("failed request reports an address");

    // a copy is reported only together with a new address
    a_copy_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && copy_length != 16'd0) |-> (result_address != 16'd0 && copy_source != 16'd0))
        else $error("copy reported without a moved block");

endmodule
